/* rtl/mie_pkg.sv */
// Package: shared types and constants for the integer execute core.
package mie_pkg;

   localparam int REGISTER_COUNT = 32;
   localparam int DATA_WIDTH     = 64;
   localparam int WORD_WIDTH     = 32;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_UNDEF    = 2'd2
   } status_type;

   typedef enum logic [5:0] {
      CMD_NOP    = 6'd0,
      CMD_SLL    = 6'd1,
      CMD_SRL    = 6'd2,
      CMD_SRA    = 6'd3,
      CMD_SLLV   = 6'd4,
      CMD_SRLV   = 6'd5,
      CMD_SRAV   = 6'd6,
      CMD_DSLL   = 6'd7,
      CMD_DSRL   = 6'd8,
      CMD_DSRA   = 6'd9,
      CMD_DSLL32 = 6'd10,
      CMD_DSRL32 = 6'd11,
      CMD_DSRA32 = 6'd12,
      CMD_DSLLV  = 6'd13,
      CMD_DSRLV  = 6'd14,
      CMD_DSRAV  = 6'd15,
      CMD_ADD    = 6'd16,
      CMD_ADDU   = 6'd17,
      CMD_SUB    = 6'd18,
      CMD_SUBU   = 6'd19,
      CMD_DADD   = 6'd20,
      CMD_DADDU  = 6'd21,
      CMD_DSUB   = 6'd22,
      CMD_DSUBU  = 6'd23,
      CMD_AND    = 6'd24,
      CMD_OR     = 6'd25,
      CMD_XOR    = 6'd26,
      CMD_NOR    = 6'd27,
      CMD_SLT    = 6'd28,
      CMD_SLTU   = 6'd29,
      CMD_ADDI   = 6'd30,
      CMD_ADDIU  = 6'd31,
      CMD_DADDI  = 6'd32,
      CMD_DADDIU = 6'd33,
      CMD_SLTI   = 6'd34,
      CMD_SLTIU  = 6'd35,
      CMD_ANDI   = 6'd36,
      CMD_ORI    = 6'd37,
      CMD_XORI   = 6'd38,
      CMD_LUI    = 6'd39
   } cmd_type;

   typedef struct packed {
      logic [5:0]  command;
      logic [4:0]  source_index;
      logic [4:0]  target_index;
      logic [4:0]  dest_index;
      logic [15:0] immediate_value;
      logic [4:0]  shift_field;
      logic [31:0] raw_word;
      logic [31:0] instr_address;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        write_enable;
      logic [4:0]  write_index;
      logic [63:0] write_value;
      logic [31:0] fault_address;
      logic [31:0] rejected_word;
   } rsp_type;

   function automatic logic [63:0] sext_word(input logic [31:0] w);
      return {{32{w[31]}}, w};
   endfunction

   function automatic logic is_word(input logic [63:0] v);
      return v[63:32] == {32{v[31]}};
   endfunction

endpackage

/* rtl/mie_channels.sv */
// Interfaces: request and response channels of the integer execute core.
interface mie_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  command;
   logic [4:0]  source_index;
   logic [4:0]  target_index;
   logic [4:0]  dest_index;
   logic [15:0] immediate_value;
   logic [4:0]  shift_field;
   logic [31:0] raw_word;
   logic [31:0] instr_address;

   modport source (
      output valid, command, source_index, target_index, dest_index,
             immediate_value, shift_field, raw_word, instr_address,
      input  ready
   );
   modport sink (
      input  valid, command, source_index, target_index, dest_index,
             immediate_value, shift_field, raw_word, instr_address,
      output ready
   );
endinterface

interface mie_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        write_enable;
   logic [4:0]  write_index;
   logic [63:0] write_value;
   logic [31:0] fault_address;
   logic [31:0] rejected_word;

   modport source (
      output valid, status, write_enable, write_index, write_value,
             fault_address, rejected_word,
      input  ready
   );
   modport sink (
      input  valid, status, write_enable, write_index, write_value,
             fault_address, rejected_word,
      output ready
   );
endinterface

/* rtl/mie_ram.sv */
// Generic RAM: one write port, two registered read ports.
module mie_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

/* rtl/mie_alu.sv */
// Execute logic: operation decode, shifter, adder, compares and result formatting.
module mie_alu (
   input  mie_pkg::req_type req,
   input  logic [63:0]      s,
   input  logic [63:0]      t,
   output mie_pkg::rsp_type rsp
);

   logic [63:0]        simm;
   logic [63:0]        sum_st;
   logic [63:0]        diff_st;
   logic [63:0]        sum_si;
   logic               ovf_add32;
   logic               ovf_sub32;
   logic               ovf_addi32;
   logic               ovf_add64;
   logic               ovf_sub64;
   logic               ovf_addi64;
   logic [4:0]         amt5;
   logic [5:0]         amt6;
   logic [31:0]        w_sll;
   logic [31:0]        w_srl;
   logic [31:0]        w_sra;
   logic [63:0]        d_sll;
   logic [63:0]        d_srl;
   logic [63:0]        d_sra;
   mie_pkg::status_type status;
   logic               wr;
   logic [4:0]         dest;
   logic [63:0]        val;

   assign simm    = {{48{req.immediate_value[15]}}, req.immediate_value};
   assign sum_st  = s + t;
   assign diff_st = s - t;
   assign sum_si  = s + simm;

   assign ovf_add32  = ~(s[31] ^ t[31]) & (s[31] ^ sum_st[31]);
   assign ovf_sub32  = (s[31] ^ t[31]) & (s[31] ^ diff_st[31]);
   assign ovf_addi32 = ~(s[31] ^ simm[31]) & (s[31] ^ sum_si[31]);
   assign ovf_add64  = ~(s[63] ^ t[63]) & (s[63] ^ sum_st[63]);
   assign ovf_sub64  = (s[63] ^ t[63]) & (s[63] ^ diff_st[63]);
   assign ovf_addi64 = ~(s[63] ^ simm[63]) & (s[63] ^ sum_si[63]);

   always_comb begin
      case (req.command)
         mie_pkg::CMD_SLLV, mie_pkg::CMD_SRLV, mie_pkg::CMD_SRAV: amt5 = s[4:0];
         default: amt5 = req.shift_field;
      endcase
      case (req.command)
         mie_pkg::CMD_DSLL32, mie_pkg::CMD_DSRL32, mie_pkg::CMD_DSRA32:
            amt6 = {1'b1, req.shift_field};
         mie_pkg::CMD_DSLLV, mie_pkg::CMD_DSRLV, mie_pkg::CMD_DSRAV: amt6 = s[5:0];
         default: amt6 = {1'b0, req.shift_field};
      endcase
   end

   assign w_sll = t[31:0] << amt5;
   assign w_srl = t[31:0] >> amt5;
   assign w_sra = 32'($signed(t[31:0]) >>> amt5);
   assign d_sll = t << amt6;
   assign d_srl = t >> amt6;
   assign d_sra = 64'($signed(t) >>> amt6);

   always_comb begin
      status = mie_pkg::STATUS_OK;
      wr     = 1'b0;
      dest   = req.dest_index;
      val    = '0;
      case (req.command)
         mie_pkg::CMD_NOP: begin
         end
         mie_pkg::CMD_SLL, mie_pkg::CMD_SLLV: begin
            if (!mie_pkg::is_word(t)) status = mie_pkg::STATUS_UNDEF;
            else begin
               wr  = 1'b1;
               val = mie_pkg::sext_word(w_sll);
            end
         end
         mie_pkg::CMD_SRL, mie_pkg::CMD_SRLV: begin
            if (!mie_pkg::is_word(t)) status = mie_pkg::STATUS_UNDEF;
            else begin
               wr  = 1'b1;
               val = mie_pkg::sext_word(w_srl);
            end
         end
         mie_pkg::CMD_SRA, mie_pkg::CMD_SRAV: begin
            if (!mie_pkg::is_word(t)) status = mie_pkg::STATUS_UNDEF;
            else begin
               wr  = 1'b1;
               val = mie_pkg::sext_word(w_sra);
            end
         end
         mie_pkg::CMD_DSLL, mie_pkg::CMD_DSLL32, mie_pkg::CMD_DSLLV: begin
            wr  = 1'b1;
            val = d_sll;
         end
         mie_pkg::CMD_DSRL, mie_pkg::CMD_DSRL32, mie_pkg::CMD_DSRLV: begin
            wr  = 1'b1;
            val = d_srl;
         end
         mie_pkg::CMD_DSRA, mie_pkg::CMD_DSRA32, mie_pkg::CMD_DSRAV: begin
            wr  = 1'b1;
            val = d_sra;
         end
         mie_pkg::CMD_ADD, mie_pkg::CMD_ADDU: begin
            if (!mie_pkg::is_word(s) || !mie_pkg::is_word(t)) begin
               status = mie_pkg::STATUS_UNDEF;
            end else if (req.command == mie_pkg::CMD_ADD && ovf_add32) begin
               status = mie_pkg::STATUS_OVERFLOW;
            end else begin
               wr  = 1'b1;
               val = mie_pkg::sext_word(sum_st[31:0]);
            end
         end
         mie_pkg::CMD_SUB, mie_pkg::CMD_SUBU: begin
            if (!mie_pkg::is_word(s) || !mie_pkg::is_word(t)) begin
               status = mie_pkg::STATUS_UNDEF;
            end else if (req.command == mie_pkg::CMD_SUB && ovf_sub32) begin
               status = mie_pkg::STATUS_OVERFLOW;
            end else begin
               wr  = 1'b1;
               val = mie_pkg::sext_word(diff_st[31:0]);
            end
         end
         mie_pkg::CMD_DADD, mie_pkg::CMD_DADDU: begin
            if (req.command == mie_pkg::CMD_DADD && ovf_add64) begin
               status = mie_pkg::STATUS_OVERFLOW;
            end else begin
               wr  = 1'b1;
               val = sum_st;
            end
         end
         mie_pkg::CMD_DSUB, mie_pkg::CMD_DSUBU: begin
            if (req.command == mie_pkg::CMD_DSUB && ovf_sub64) begin
               status = mie_pkg::STATUS_OVERFLOW;
            end else begin
               wr  = 1'b1;
               val = diff_st;
            end
         end
         mie_pkg::CMD_AND: begin
            wr  = 1'b1;
            val = s & t;
         end
         mie_pkg::CMD_OR: begin
            wr  = 1'b1;
            val = s | t;
         end
         mie_pkg::CMD_XOR: begin
            wr  = 1'b1;
            val = s ^ t;
         end
         mie_pkg::CMD_NOR: begin
            wr  = 1'b1;
            val = ~(s | t);
         end
         mie_pkg::CMD_SLT: begin
            wr  = 1'b1;
            val = {63'd0, $signed(s) < $signed(t)};
         end
         mie_pkg::CMD_SLTU: begin
            wr  = 1'b1;
            val = {63'd0, s < t};
         end
         mie_pkg::CMD_ADDI, mie_pkg::CMD_ADDIU: begin
            dest = req.target_index;
            if (!mie_pkg::is_word(s)) begin
               status = mie_pkg::STATUS_UNDEF;
            end else if (req.command == mie_pkg::CMD_ADDI && ovf_addi32) begin
               status = mie_pkg::STATUS_OVERFLOW;
            end else begin
               wr  = 1'b1;
               val = mie_pkg::sext_word(sum_si[31:0]);
            end
         end
         mie_pkg::CMD_DADDI, mie_pkg::CMD_DADDIU: begin
            dest = req.target_index;
            if (req.command == mie_pkg::CMD_DADDI && ovf_addi64) begin
               status = mie_pkg::STATUS_OVERFLOW;
            end else begin
               wr  = 1'b1;
               val = sum_si;
            end
         end
         mie_pkg::CMD_SLTI: begin
            dest = req.target_index;
            wr   = 1'b1;
            val  = {63'd0, $signed(s) < $signed(simm)};
         end
         mie_pkg::CMD_SLTIU: begin
            dest = req.target_index;
            wr   = 1'b1;
            val  = {63'd0, s < simm};
         end
         mie_pkg::CMD_ANDI: begin
            dest = req.target_index;
            wr   = 1'b1;
            val  = s & {48'd0, req.immediate_value};
         end
         mie_pkg::CMD_ORI: begin
            dest = req.target_index;
            wr   = 1'b1;
            val  = s | {48'd0, req.immediate_value};
         end
         mie_pkg::CMD_XORI: begin
            dest = req.target_index;
            wr   = 1'b1;
            val  = s ^ {48'd0, req.immediate_value};
         end
         mie_pkg::CMD_LUI: begin
            dest = req.target_index;
            wr   = 1'b1;
            val  = mie_pkg::sext_word({req.immediate_value, 16'd0});
         end
         default: status = mie_pkg::STATUS_UNDEF;
      endcase
   end

   always_comb begin
      rsp.status        = status;
      rsp.write_enable  = 1'b0;
      rsp.write_index   = '0;
      rsp.write_value   = '0;
      rsp.fault_address = '0;
      rsp.rejected_word = '0;
      if (status == mie_pkg::STATUS_OK && wr && dest != '0) begin
         rsp.write_enable = 1'b1;
         rsp.write_index  = dest;
         rsp.write_value  = val;
      end
      if (status != mie_pkg::STATUS_OK) begin
         rsp.fault_address = req.instr_address;
         rsp.rejected_word = req.raw_word;
      end
   end

endmodule

/* rtl/mips64_integer_alu_execute_core.sv */
// Top level: integer execute core with register file, execute stage and result register.
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+-------------------------------------------
//   req_bus  | in        | valid/ready      | decoded instruction, indexes, immediate
//   rsp_bus  | out       | valid/ready      | status, register write, fault information
//
// One transaction per cycle sustained unless the response stalls. A request goes from the
// register file read into the execute register, then execute into the result register.
// The register file write happens as a result enters the result register; a request
// accepted at that same edge picks the new value up through a forwarding register.
// Reset clears the valid bits of the register file at once; unwritten registers read zero.
// A stalled response holds the execute stage; requests are taken while it is empty or can advance.
module mips64_integer_alu_execute_core #(
   parameter int REGISTER_COUNT = mie_pkg::REGISTER_COUNT
) (
   input logic        clock,
   input logic        reset,
   mie_req_if.sink    req_bus,
   mie_rsp_if.source  rsp_bus
);

   localparam int IndexWidth = $clog2(REGISTER_COUNT);

   mie_pkg::req_type          req;
   logic                      req_accept;
   logic                      s1_advance;
   logic                      s1_valid_ff, s1_valid_in;
   mie_pkg::req_type          s1_req_ff;
   logic                      s_live_ff, t_live_ff;
   logic                      s_hit_ff, t_hit_ff;
   logic [63:0]               wb_value_ff;
   logic [63:0]               ram_s, ram_t;
   logic [63:0]               op_s, op_t;
   mie_pkg::rsp_type          alu_rsp;
   logic                      out_valid_ff, out_valid_in;
   mie_pkg::rsp_type          out_ff;
   logic [REGISTER_COUNT-1:0] valid_ff, valid_in;
   logic                      wb_en;
   logic [IndexWidth-1:0]     wb_idx;
   logic [IndexWidth-1:0]     rs_idx, rt_idx;
   logic                      s_hit, t_hit;

   assign req.command         = req_bus.command;
   assign req.source_index    = req_bus.source_index;
   assign req.target_index    = req_bus.target_index;
   assign req.dest_index      = req_bus.dest_index;
   assign req.immediate_value = req_bus.immediate_value;
   assign req.shift_field     = req_bus.shift_field;
   assign req.raw_word        = req_bus.raw_word;
   assign req.instr_address   = req_bus.instr_address;

   assign s1_advance    = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign wb_en  = s1_advance && alu_rsp.write_enable;
   assign wb_idx = alu_rsp.write_index[IndexWidth-1:0];
   assign rs_idx = req.source_index[IndexWidth-1:0];
   assign rt_idx = req.target_index[IndexWidth-1:0];
   assign s_hit  = wb_en && (wb_idx == rs_idx);
   assign t_hit  = wb_en && (wb_idx == rt_idx);

   mie_ram #(
      .WIDTH (mie_pkg::DATA_WIDTH),
      .DEPTH (REGISTER_COUNT)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (wb_en),
      .wr_addr   (wb_idx),
      .wr_data   (alu_rsp.write_value),
      .rd_en     (req_accept),
      .rd_addr_a (rs_idx),
      .rd_addr_b (rt_idx),
      .rd_data_a (ram_s),
      .rd_data_b (ram_t)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wb_en) begin
         valid_in[wb_idx] = 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) s1_valid_in = 1'b1;
      else if (s1_advance) s1_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (s1_advance) out_valid_in = 1'b1;
      else if (rsp_bus.ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff   <= req;
         s_live_ff   <= valid_ff[rs_idx] || s_hit;
         t_live_ff   <= valid_ff[rt_idx] || t_hit;
         s_hit_ff    <= s_hit;
         t_hit_ff    <= t_hit;
         wb_value_ff <= alu_rsp.write_value;
      end
      if (s1_advance) begin
         out_ff <= alu_rsp;
      end
   end

   assign op_s = !s_live_ff ? '0 : (s_hit_ff ? wb_value_ff : ram_s);
   assign op_t = !t_live_ff ? '0 : (t_hit_ff ? wb_value_ff : ram_t);

   mie_alu u_alu (
      .req (s1_req_ff),
      .s   (op_s),
      .t   (op_t),
      .rsp (alu_rsp)
   );

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.status        = out_ff.status;
   assign rsp_bus.write_enable  = out_ff.write_enable;
   assign rsp_bus.write_index   = out_ff.write_index;
   assign rsp_bus.write_value   = out_ff.write_value;
   assign rsp_bus.fault_address = out_ff.fault_address;
   assign rsp_bus.rejected_word = out_ff.rejected_word;

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      wb_en |-> wb_idx != '0)
      else $error("register zero written");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_req_ff))
      else $error("execute stage lost a transaction while stalled");

   a_wb_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wb_en |=> valid_ff[$past(wb_idx)])
      else $error("written register not marked valid");

   a_fault_no_write: assert property (@(posedge clock) disable iff (reset)
      s1_advance && alu_rsp.status != mie_pkg::STATUS_OK |-> !wb_en)
      else $error("faulting transaction wrote the register file");

endmodule
